FILE: design/kems_pkg.sv
// Package for the keyed entry merge sorter.
// Holds sizing constants, controller state type and the control/status structs.
// No dependencies.
package kems_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 4;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [0:0] {
        S_LOAD = 1'b0,
        S_EMIT = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // request accepted on the input side
        logic adv;    // result taken, step to next sorted entry
        logic clear;  // set finished, empty the store
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;   // read pointer is on the final stored entry
    } t_dp_stat;

endpackage

FILE: design/keyed_entry_merge_sorter_top.sv
// Keyed entry merge sorter, top level.
//
// Input channel (i_in_valid / o_in_ready) takes one entry per cycle while
// loading: a 32-bit unsigned key and a 4-bit tag. The request with i_is_final
// high closes the set. Up to MAX_ENTRIES entries are kept; later ones are
// dropped and the drop is reported on o_overflowed with the final result.
// Each entry is inserted into a sorted cell row as it arrives. Equal keys
// keep their arrival order.
// From the cycle after the final request the results appear on
// o_out_valid / i_out_ready, one per cycle while the receiver is ready,
// ascending by key, with o_out_last on the last one. Input is not taken
// while results are being emitted.
// A stalled receiver simply holds the current result; nothing is lost.
// Reset (i_rst_n, synchronous, active low) empties the set and returns the
// block to loading.
// Depends on kems_pkg, kems_ctrl and kems_datapath.
module keyed_entry_merge_sorter_top import kems_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [KEY_W-1:0] i_sort_key,
    input  logic [TAG_W-1:0] i_entry_tag,
    input  logic             i_is_final,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [KEY_W-1:0] o_out_key,
    output logic [TAG_W-1:0] o_out_tag,
    output logic             o_out_last,
    output logic             o_overflowed
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     ovf;

    kems_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_is_final  (i_is_final),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    kems_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sort_key  (i_sort_key),
        .i_entry_tag (i_entry_tag),
        .o_stat      (stat),
        .o_out_key   (o_out_key),
        .o_out_tag   (o_out_tag),
        .o_overflow  (ovf)
    );

    assign o_out_last   = stat.last;
    assign o_overflowed = stat.last && ovf;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("load and emit active together");

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_is_final) |=> (o_out_valid && !o_in_ready))
        else $error("no results after final request");

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_last) |=> (o_in_ready && !o_out_valid))
        else $error("block did not return to loading after last result");

    a_ovf_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_overflowed |-> (o_out_valid && o_out_last))
        else $error("overflow flagged away from last result");

endmodule

FILE: design/kems_ctrl.sv
// Controller state machine for the keyed entry merge sorter.
// Sequences loading and emitting; depends on kems_pkg.
module kems_ctrl import kems_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_is_final,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_is_final) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.adv   = i_out_ready;
                if (i_out_ready && i_stat.last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

FILE: design/kems_datapath.sv
// Datapath for the keyed entry merge sorter: a row of sorted entry cells
// filled by insertion, plus fill count, overflow flag and read pointer.
// Depends on kems_pkg.
module kems_datapath import kems_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [KEY_W-1:0] i_sort_key,
    input  logic [TAG_W-1:0] i_entry_tag,
    output t_dp_stat         o_stat,
    output logic [KEY_W-1:0] o_out_key,
    output logic [TAG_W-1:0] o_out_tag,
    output logic             o_overflow
);

    logic [KEY_W-1:0] r_key [MAX_ENTRIES];
    logic [TAG_W-1:0] r_tag [MAX_ENTRIES];
    logic [KEY_W-1:0] n_key [MAX_ENTRIES];
    logic [TAG_W-1:0] n_tag [MAX_ENTRIES];
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_ovf;
    logic [MAX_ENTRIES-1:0] gt;
    logic             full;

    assign full = (r_count == CNT_W'(MAX_ENTRIES));

    // Cells are kept in ascending order. Empty cells count as greater than any
    // key; a new entry lands after every cell with key <= new key (stable).
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            gt[i] = (CNT_W'(i) >= r_count) || (r_key[i] > i_sort_key);
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_key[i] = r_key[i];
            n_tag[i] = r_tag[i];
            if (gt[i]) begin
                if (i == 0) begin
                    n_key[i] = i_sort_key;
                    n_tag[i] = i_entry_tag;
                end else if (!gt[i-1]) begin
                    n_key[i] = i_sort_key;
                    n_tag[i] = i_entry_tag;
                end else begin
                    n_key[i] = r_key[i-1];
                    n_tag[i] = r_tag[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_key[i] <= n_key[i];
                r_tag[i] <= n_tag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_idx <= '0;
        end else if (i_cmd.clear) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.adv) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    assign o_stat.last = ({1'b0, r_rd_idx} == (r_count - 1'b1));
    assign o_out_key   = r_key[r_rd_idx];
    assign o_out_tag   = r_tag[r_rd_idx];
    assign o_overflow  = r_ovf;

endmodule

FILE: verif/keyed_entry_merge_sorter_top_test.sv
// Self-checking bench for keyed_entry_merge_sorter_top: loads keyed sets and checks sorted output.
// Holds its own stable-sort predictor and random source gaps and sink stalls.
// Depends on kems_pkg and keyed_entry_merge_sorter_top.
`timescale 1ns / 100ps

module keyed_entry_merge_sorter_top_test;
    import kems_pkg::*;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH
    } t_pace;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             final_entry;
        t_pace            pace;
    } t_entry_req;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             ovf;
    } t_sorted_entry;

    localparam int TARGET_STORED = 500;
    localparam int TAIL_CYCLES   = 40;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_ready;
    logic [KEY_W-1:0] i_sort_key   = '0;
    logic [TAG_W-1:0] i_entry_tag  = '0;
    logic             i_is_final   = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready  = 1'b0;
    logic [KEY_W-1:0] o_out_key;
    logic [TAG_W-1:0] o_out_tag;
    logic             o_out_last;
    logic             o_overflowed;

    t_entry_req    entry_q[$];
    t_sorted_entry sorted_run_q[$];
    t_pace         cur_pace       = PH_STEADY;
    int            requests_taken = 0;
    int            requests_total = 0;
    bit            fail_seen      = 1'b0;

    // predictor's copy of the set being loaded
    logic [KEY_W-1:0] held_keys [MAX_ENTRIES];
    logic [TAG_W-1:0] held_tags [MAX_ENTRIES];
    int               held_count    = 0;
    logic             held_overflow = 1'b0;

    keyed_entry_merge_sorter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sort_key   (i_sort_key),
        .i_entry_tag  (i_entry_tag),
        .i_is_final   (i_is_final),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_key    (o_out_key),
        .o_out_tag    (o_out_tag),
        .o_out_last   (o_out_last),
        .o_overflowed (o_overflowed)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic queue_entry(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                               logic final_entry, t_pace pace);
        t_entry_req r;
        r.key         = key;
        r.tag         = tag;
        r.final_entry = final_entry;
        r.pace        = pace;
        entry_q.push_back(r);
        requests_total++;
    endtask

    task automatic flag_mismatch(string what, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        fail_seen = 1'b1;
    endtask

    // Request driver: a held request stays put until taken.
    always @(posedge i_clk) begin
        t_entry_req nxt;
        logic       gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            gap = 1'b0;
            if (entry_q.size() != 0) begin
                case (entry_q[0].pace)
                    PH_SRC_GAPS: gap = ($urandom_range(99) < 53);
                    PH_BOTH:     gap = ($urandom_range(99) < 23);
                    default:     gap = 1'b0;
                endcase
            end
            if (entry_q.size() != 0 && !gap) begin
                nxt = entry_q.pop_front();
                i_in_valid  <= 1'b1;
                i_sort_key  <= nxt.key;
                i_entry_tag <= nxt.tag;
                i_is_final  <= nxt.final_entry;
                cur_pace    <= nxt.pace;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        case (cur_pace)
            PH_SINK_STALLS: i_out_ready <= ($urandom_range(99) >= 53);
            PH_BOTH:        i_out_ready <= ($urandom_range(99) >= 23);
            default:        i_out_ready <= 1'b1;
        endcase
    end

    // Predictor: store each taken request, sort stably when the set closes.
    always @(posedge i_clk) begin : sort_predictor
        logic [KEY_W-1:0] keys [MAX_ENTRIES];
        logic [TAG_W-1:0] tags [MAX_ENTRIES];
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        int               j;
        t_sorted_entry    res;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            requests_taken <= requests_taken + 1;
            if (held_count < MAX_ENTRIES) begin
                held_keys[held_count] = i_sort_key;
                held_tags[held_count] = i_entry_tag;
                held_count++;
            end else begin
                held_overflow = 1'b1;
            end
            if (i_is_final) begin
                keys = held_keys;
                tags = held_tags;
                // move left only past strictly greater keys, so ties keep load order
                for (int i = 1; i < held_count; i++) begin
                    k = keys[i];
                    t = tags[i];
                    j = i;
                    while (j > 0 && keys[j-1] > k) begin
                        keys[j] = keys[j-1];
                        tags[j] = tags[j-1];
                        j--;
                    end
                    keys[j] = k;
                    tags[j] = t;
                end
                for (int i = 0; i < held_count; i++) begin
                    res.key  = keys[i];
                    res.tag  = tags[i];
                    res.last = (i == held_count - 1);
                    res.ovf  = res.last && held_overflow;
                    sorted_run_q.push_back(res);
                end
                held_count    = 0;
                held_overflow = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sorted_entry want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sorted_run_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got key %h tag %h",
                         $time, o_out_key, o_out_tag);
                fail_seen = 1'b1;
            end else begin
                want = sorted_run_q.pop_front();
                if (o_out_key !== want.key)
                    flag_mismatch("key", want.key, o_out_key);
                if (o_out_tag !== want.tag)
                    flag_mismatch("tag", KEY_W'(want.tag), KEY_W'(o_out_tag));
                if (o_out_last !== want.last)
                    flag_mismatch("last", KEY_W'(want.last), KEY_W'(o_out_last));
                if (o_overflowed !== want.ovf)
                    flag_mismatch("overflow", KEY_W'(want.ovf), KEY_W'(o_overflowed));
            end
        end
    end

    initial begin
        int               stored_total;
        int               set_num;
        int               set_len;
        int               key_mode;
        t_pace            pace;
        logic [KEY_W-1:0] key;

        // lone entry
        queue_entry('0, '0, 1'b1, PH_STEADY);
        // extremes and a run of equal keys whose tags must stay in load order
        queue_entry(32'd5, 4'd1, 1'b0, PH_STEADY);
        queue_entry(32'd5, 4'd2, 1'b0, PH_STEADY);
        queue_entry('1, 4'hF, 1'b0, PH_STEADY);
        queue_entry('0, 4'd0, 1'b0, PH_STEADY);
        queue_entry(32'd5, 4'd3, 1'b0, PH_STEADY);
        queue_entry(32'h8000_0000, 4'd9, 1'b1, PH_STEADY);
        // one past capacity, the closing entry itself is dropped
        for (int i = 0; i <= MAX_ENTRIES; i++)
            queue_entry(32'hFFFF_FFF0 - KEY_W'(i), TAG_W'(i), i == MAX_ENTRIES, PH_STEADY);
        stored_total = 7 + MAX_ENTRIES;

        set_num = 0;
        while (stored_total < TARGET_STORED) begin
            pace     = t_pace'((set_num / 6) % 4);
            key_mode = $urandom_range(3);
            case ($urandom_range(9))
                0:       set_len = MAX_ENTRIES;
                1:       set_len = MAX_ENTRIES + $urandom_range(1, 6);
                default: set_len = $urandom_range(1, MAX_ENTRIES - 1);
            endcase
            for (int i = 0; i < set_len; i++) begin
                case (key_mode)
                    0:       key = $urandom;
                    1:       key = $urandom_range(7);
                    2:       key = $urandom_range(1) ? '1 : '0;
                    default: key = 32'hFFFF_FFFF - $urandom_range(7);
                endcase
                queue_entry(key, TAG_W'($urandom_range(15)), i == set_len - 1, pace);
            end
            stored_total += (set_len < MAX_ENTRIES) ? set_len : MAX_ENTRIES;
            set_num++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken != requests_total) @(posedge i_clk);
        while (sorted_run_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (!fail_seen) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout, %0d of %0d requests taken", requests_taken, requests_total);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
